/* src/fdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fdc_pkg;

   localparam int QUO_W = 27;
   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [30:0] INF_MAG = 31'h7F80_0000;
   localparam logic CSR_CLAMP_LOW = 1'b0;
   localparam logic CSR_CLAMP_HIGH = 1'b1;

   typedef struct packed {
      logic valid;
      logic last;
      logic sign;
      logic spec;
      logic [31:0] spec_bits;
      logic signed [9:0] exp;
   } fdc_side_type;

   typedef struct packed {
      fdc_side_type side;
      logic [23:0] dvs;
      logic [24:0] rem;
      logic [QUO_W-1:0] quo;
   } fdc_div_type;

endpackage
`default_nettype wire

/* src/f32_divide_clamp.sv */
// pipeline registers from item accept to result valid: 2 unpack, 27 divider cells, 3 round/clamp
// throughput: one item per cycle when not stalled; the divider is a row of 27 cells, one quotient bit each
// the whole pipeline advances together, stalling only while the result register is held
// reset (synchronous, active high) empties the pipeline and loads the clamp bounds
// to -100.0 and +100.0
`timescale 1ns / 1ps
`default_nettype none
module f32_divide_clamp import fdc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [31:0] req_dividend_bits,
   input wire logic [31:0] req_divisor_bits,
   input wire logic req_last_in,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [31:0] rsp_quotient_bits,
   output logic rsp_last_out,
   input wire logic csr_write_en,
   input wire logic csr_index,
   input wire logic [31:0] csr_wdata
);

   logic adv;
   logic [31:0] low_ff, high_ff;
   fdc_div_type chain [0:QUO_W];

   assign adv = ~rsp_valid | rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= 32'hC2C8_0000;
         high_ff <= 32'h42C8_0000;
      end else if (csr_write_en) begin
         if (csr_index == CSR_CLAMP_LOW) low_ff <= csr_wdata;
         if (csr_index == CSR_CLAMP_HIGH) high_ff <= csr_wdata;
      end
   end

   fdc_front u_front (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(req_valid),
      .a(req_dividend_bits),
      .b(req_divisor_bits),
      .last(req_last_in),
      .out(chain[0])
   );

   for (genvar i = 0; i < QUO_W; i++) begin : g_cell
      fdc_cell u_cell (
         .clock(clock),
         .reset(reset),
         .adv(adv),
         .prev(chain[i]),
         .next(chain[i+1])
      );
   end

   fdc_back u_back (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .div(chain[QUO_W]),
      .low_bits(low_ff),
      .high_bits(high_ff),
      .out_valid(rsp_valid),
      .out_bits(rsp_quotient_bits),
      .out_last(rsp_last_out)
   );

endmodule
`default_nettype wire

/* src/fdc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module fdc_front import fdc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic adv,
   input wire logic in_valid,
   input wire logic [31:0] a,
   input wire logic [31:0] b,
   input wire logic last,
   output fdc_div_type out
);

   typedef struct packed {
      fdc_side_type side;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [4:0] sa;
      logic [4:0] sb;
      logic signed [9:0] ea;
      logic signed [9:0] eb;
   } fdc_unp_type;

   fdc_unp_type unp_ff, unp_in;
   fdc_div_type div_ff, div_in;

   function automatic logic [4:0] lead_zeros(input logic [23:0] x);
      logic [4:0] n;
      n = 5'd24;
      for (int i = 0; i < 24; i++) begin
         if (x[i]) n = 5'(23 - i);
      end
      return n;
   endfunction

   logic [30:0] aa, ba;
   logic sign;
   logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

   always_comb begin
      aa = a[30:0];
      ba = b[30:0];
      sign = a[31] ^ b[31];
      a_nan = aa > INF_MAG;
      b_nan = ba > INF_MAG;
      a_inf = aa == INF_MAG;
      b_inf = ba == INF_MAG;
      a_zero = aa == 31'd0;
      b_zero = ba == 31'd0;
      unp_in = '0;
      unp_in.side.valid = in_valid;
      unp_in.side.last = last;
      unp_in.side.sign = sign;
      unp_in.side.spec = 1'b1;
      if (a_nan || b_nan) begin
         unp_in.side.spec_bits = QNAN_BITS;
      end else if (a_inf) begin
         unp_in.side.spec_bits = b_inf ? QNAN_BITS : {sign, INF_MAG};
      end else if (b_inf) begin
         unp_in.side.spec_bits = {sign, 31'd0};
      end else if (b_zero) begin
         unp_in.side.spec_bits = a_zero ? QNAN_BITS : {sign, INF_MAG};
      end else if (a_zero) begin
         unp_in.side.spec_bits = {sign, 31'd0};
      end else begin
         unp_in.side.spec = 1'b0;
         unp_in.side.spec_bits = QNAN_BITS;
      end
      unp_in.ma = {a[30:23] != 8'd0, a[22:0]};
      unp_in.mb = {b[30:23] != 8'd0, b[22:0]};
      unp_in.sa = (a[30:23] == 8'd0) ? lead_zeros(unp_in.ma) : 5'd0;
      unp_in.sb = (b[30:23] == 8'd0) ? lead_zeros(unp_in.mb) : 5'd0;
      unp_in.ea = (a[30:23] == 8'd0) ? 10'sd1 - $signed({5'd0, unp_in.sa})
                                     : $signed({2'd0, a[30:23]});
      unp_in.eb = (b[30:23] == 8'd0) ? 10'sd1 - $signed({5'd0, unp_in.sb})
                                     : $signed({2'd0, b[30:23]});
   end

   logic [23:0] ma_n, mb_n;
   logic lt;

   always_comb begin
      ma_n = unp_ff.ma << unp_ff.sa;
      mb_n = unp_ff.mb << unp_ff.sb;
      lt = ma_n < mb_n;
      div_in.side = unp_ff.side;
      div_in.side.exp = unp_ff.ea - unp_ff.eb + 10'sd127 - $signed({9'd0, lt});
      div_in.dvs = mb_n;
      div_in.rem = lt ? {ma_n, 1'b0} : {1'b0, ma_n};
      div_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unp_ff.side.valid <= 1'b0;
         div_ff.side.valid <= 1'b0;
      end else if (adv) begin
         unp_ff <= unp_in;
         div_ff <= div_in;
      end
   end

   assign out = div_ff;

endmodule
`default_nettype wire

/* src/fdc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module fdc_cell import fdc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic adv,
   input wire fdc_div_type prev,
   output fdc_div_type next
);

   fdc_div_type cell_ff, cell_in;
   logic ge;
   logic [24:0] diff;

   always_comb begin
      ge = prev.rem >= {1'b0, prev.dvs};
      diff = ge ? prev.rem - {1'b0, prev.dvs} : prev.rem;
      cell_in = prev;
      cell_in.rem = {diff[23:0], 1'b0};
      cell_in.quo = {prev.quo[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.side.valid <= 1'b0;
      end else if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign next = cell_ff;

endmodule
`default_nettype wire

/* src/fdc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module fdc_back import fdc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic adv,
   input wire fdc_div_type div,
   input wire logic [31:0] low_bits,
   input wire logic [31:0] high_bits,
   output logic out_valid,
   output logic [31:0] out_bits,
   output logic out_last
);

   typedef struct packed {
      fdc_side_type side;
      logic ovf;
      logic [7:0] ef;
      logic [QUO_W-1:0] q;
   } fdc_den_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic [31:0] bits;
   } fdc_res_type;

   fdc_den_type den_ff, den_in;
   fdc_res_type rnd_ff, rnd_in, out_ff, out_in;

   function automatic logic is_nan(input logic [31:0] x);
      return x[30:0] > INF_MAG;
   endfunction

   function automatic logic [31:0] order_key(input logic [31:0] x);
      return x[31] ? ~x : (x | 32'h8000_0000);
   endfunction

   function automatic logic [31:0] max_num(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] r;
      if (is_nan(x) && is_nan(y)) r = QNAN_BITS;
      else if (is_nan(x)) r = y;
      else if (is_nan(y)) r = x;
      else r = (order_key(x) >= order_key(y)) ? x : y;
      return r;
   endfunction

   function automatic logic [31:0] min_num(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] r;
      if (is_nan(x) && is_nan(y)) r = QNAN_BITS;
      else if (is_nan(x)) r = y;
      else if (is_nan(y)) r = x;
      else r = (order_key(x) <= order_key(y)) ? x : y;
      return r;
   endfunction

   logic [QUO_W-1:0] q0;
   logic [9:0] sh;
   logic lost;

   always_comb begin
      q0 = {div.quo[QUO_W-1:1], div.quo[0] | (div.rem != 25'd0)};
      sh = 10'(10'sd1 - div.side.exp);
      lost = 1'b0;
      den_in.side = div.side;
      den_in.ovf = div.side.exp >= 10'sd255;
      den_in.ef = 8'(div.side.exp - 10'sd1);
      den_in.q = q0;
      if (div.side.exp <= 10'sd0) begin
         den_in.ef = 8'd0;
         if (sh >= 10'(QUO_W)) begin
            den_in.q = 27'd1;
         end else begin
            lost = (q0 & ~({QUO_W{1'b1}} << sh[4:0])) != '0;
            den_in.q = (q0 >> sh[4:0]) | {26'd0, lost};
         end
      end
   end

   logic inc;
   logic [30:0] sum;

   always_comb begin
      inc = (den_ff.q[2:0] > 3'd4) || (den_ff.q[2:0] == 3'd4 && den_ff.q[3]);
      sum = {den_ff.ef, 23'd0} + {7'd0, den_ff.q[26:3]} + {30'd0, inc};
      rnd_in.valid = den_ff.side.valid;
      rnd_in.last = den_ff.side.last;
      if (den_ff.side.spec) begin
         rnd_in.bits = den_ff.side.spec_bits;
      end else if (den_ff.ovf) begin
         rnd_in.bits = {den_ff.side.sign, INF_MAG};
      end else begin
         rnd_in.bits = {den_ff.side.sign, sum};
      end
   end

   always_comb begin
      out_in.valid = rnd_ff.valid;
      out_in.last = rnd_ff.last;
      out_in.bits = min_num(max_num(rnd_ff.bits, low_bits), high_bits);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         den_ff.side.valid <= 1'b0;
         rnd_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         den_ff <= den_in;
         rnd_ff <= rnd_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = out_ff.valid;
   assign out_bits = out_ff.bits;
   assign out_last = out_ff.last;

endmodule
`default_nettype wire

/* sim/fdc_checker.sv */
`timescale 1ns / 1ps
module fdc_checker import fdc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic [31:0] req_dividend_bits,
   input wire logic [31:0] req_divisor_bits,
   input wire logic req_last_in,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [31:0] rsp_quotient_bits,
   input wire logic rsp_last_out,
   input wire logic csr_write_en,
   input wire logic csr_index,
   input wire logic [31:0] csr_wdata,
   output int fail_count,
   output int pending_count
);

   typedef struct packed {
      logic [31:0] quotient;
      logic last;
   } quotient_item_type;

   quotient_item_type quotient_q[$];
   logic [31:0] bound_low;
   logic [31:0] bound_high;

   function automatic logic f32_is_nan(input logic [31:0] x);
      return x[30:0] > INF_MAG;
   endfunction

   function automatic logic [31:0] order_key(input logic [31:0] x);
      return x[31] ? ~x : (x | 32'h8000_0000);
   endfunction

   // maxNum when take_max, else minNum
   function automatic logic [31:0] num_select(input logic [31:0] x, input logic [31:0] y,
                                              input logic take_max);
      if (f32_is_nan(x) && f32_is_nan(y)) return QNAN_BITS;
      if (f32_is_nan(x)) return y;
      if (f32_is_nan(y)) return x;
      if (take_max) return (order_key(x) >= order_key(y)) ? x : y;
      return (order_key(x) <= order_key(y)) ? x : y;
   endfunction

   function automatic logic [31:0] norm_significand(input logic [30:0] x, output int ex);
      logic [31:0] m;
      ex = int'(x[30:23]);
      m = {9'd0, x[22:0]};
      if (ex == 0) begin
         ex = 1;
         while (m[23] == 1'b0) begin
            m = m << 1;
            ex = ex - 1;
         end
      end else begin
         m[23] = 1'b1;
      end
      return m;
   endfunction

   function automatic logic [31:0] divide_f32(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] sgn;
      logic [30:0] aa;
      logic [30:0] ba;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      logic [31:0] lost;
      logic [63:0] num;
      logic [2:0] rnd;
      int ea;
      int eb;
      int e;
      int sh;
      sgn = (a ^ b) & 32'h8000_0000;
      aa = a[30:0];
      ba = b[30:0];
      if (aa > INF_MAG || ba > INF_MAG) return QNAN_BITS;
      if (aa == INF_MAG) return (ba == INF_MAG) ? QNAN_BITS : (sgn | {1'b0, INF_MAG});
      if (ba == INF_MAG) return sgn;
      if (ba == 0) return (aa == 0) ? QNAN_BITS : (sgn | {1'b0, INF_MAG});
      if (aa == 0) return sgn;
      ma = norm_significand(aa, ea);
      mb = norm_significand(ba, eb);
      e = ea - eb + 127;
      if (ma < mb) begin
         ma = ma << 1;
         e = e - 1;
      end
      num = {32'd0, ma} << 26;
      q = 32'(num / {32'd0, mb});
      if ((num % {32'd0, mb}) != 0) q[0] = 1'b1;
      if (e >= 255) return sgn | {1'b0, INF_MAG};
      if (e <= 0) begin
         sh = 1 - e;
         if (sh >= 27) begin
            q = 32'd1;
         end else begin
            lost = q & ((32'd1 << sh) - 32'd1);
            q = (q >> sh) | ((lost != 0) ? 32'd1 : 32'd0);
         end
         e = 1;
      end
      rnd = q[2:0];
      q = q >> 3;
      if (rnd > 3'd4 || (rnd == 3'd4 && q[0])) q = q + 1;
      return sgn | ((32'(e - 1) << 23) + q);
   endfunction

   always @(posedge clock) begin
      quotient_item_type want;
      quotient_item_type got;
      if (reset) begin
         quotient_q.delete();
         bound_low <= 32'hC2C8_0000;
         bound_high <= 32'h42C8_0000;
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_CLAMP_LOW) bound_low <= csr_wdata;
            else bound_high <= csr_wdata;
         end
         if (req_valid && req_ready) begin
            want.quotient = num_select(num_select(divide_f32(req_dividend_bits,
               req_divisor_bits), bound_low, 1'b1), bound_high, 1'b0);
            want.last = req_last_in;
            quotient_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got.quotient = rsp_quotient_bits;
            got.last = rsp_last_out;
            if (quotient_q.size() == 0) begin
               $error("unexpected item: quotient_bits %h last_out %b", got.quotient, got.last);
               fail_count <= fail_count + 1;
            end else begin
               want = quotient_q.pop_front();
               if (want.quotient !== got.quotient) begin
                  $error("quotient_bits: expected %h actual %h", want.quotient, got.quotient);
                  fail_count <= fail_count + 1;
               end
               if (want.last !== got.last) begin
                  $error("last_out: expected %b actual %b", want.last, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= quotient_q.size();
      end
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import fdc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_dividend_bits = '0;
   logic [31:0] req_divisor_bits = '0;
   logic req_last_in = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_quotient_bits;
   logic rsp_last_out;
   logic csr_write_en = 1'b0;
   logic csr_index = CSR_CLAMP_LOW;
   logic [31:0] csr_wdata = '0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic no_idle = 1'b0;
   int fail_count;
   int pending_count;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      rsp_fire <= rsp_valid && rsp_ready;
   end

   f32_divide_clamp i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_dividend_bits(req_dividend_bits), .req_divisor_bits(req_divisor_bits),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_quotient_bits(rsp_quotient_bits), .rsp_last_out(rsp_last_out),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   fdc_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_dividend_bits(req_dividend_bits), .req_divisor_bits(req_divisor_bits),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_quotient_bits(rsp_quotient_bits), .rsp_last_out(rsp_last_out),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   task automatic send_item(input logic [31:0] a, input logic [31:0] b, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_dividend_bits = a;
      req_divisor_bits = b;
      req_last_in = last;
      req_valid = 1'b1;
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_bound(input logic idx, input logic [31:0] value);
      csr_index = idx;
      csr_wdata = value;
      csr_write_en = 1'b1;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   function automatic logic [31:0] pick_operand();
      logic [31:0] x;
      x = $urandom;
      case ($urandom_range(0, 9))
         0: x[30:23] = 8'd0;
         1: x[30:23] = 8'hFF;
         2: x[30:0] = $urandom_range(0, 1) ? 31'd0 : INF_MAG;
         3: x[30:23] = 8'(110 + $urandom_range(0, 40));
         4: x[30:23] = $urandom_range(0, 1) ? 8'(1 + $urandom_range(0, 6))
                                              : 8'(247 + $urandom_range(0, 7));
         5: x[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7FFFFF;
         default: x[30:23] = 8'(120 + $urandom_range(0, 14));
      endcase
      return x;
   endfunction

   task automatic random_items(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
         send_item(pick_operand(), pick_operand(), 1'($urandom_range(0, 1)));
      end
      no_idle = 1'b0;
   endtask

   initial begin
      forever begin
         int stall;
         stall = no_idle ? 0 : $urandom_range(0, 5);
         rsp_ready = 1'b0;
         repeat (stall) @(negedge clock);
         rsp_ready = 1'b1;
         do @(negedge clock); while (!rsp_fire);
      end
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;
      // directed items at the reset bounds
      send_item(32'h4040_0000, 32'h3F80_0000, 1'b0);
      send_item(32'h3F80_0000, 32'h4040_0000, 1'b1);
      send_item(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_item(32'h7F80_0000, 32'hFF80_0000, 1'b1);
      send_item(32'h7FC0_0001, 32'h3F80_0000, 1'b0);
      send_item(32'h4000_0000, 32'h8000_0000, 1'b1);
      send_item(32'hC000_0000, 32'h0000_0000, 1'b0);
      drain();
      // open bounds expose the raw quotient
      write_bound(CSR_CLAMP_LOW, 32'hFF80_0000);
      write_bound(CSR_CLAMP_HIGH, 32'h7F80_0000);
      send_item(32'h7F7F_FFFF, 32'h0000_0001, 1'b0);
      send_item(32'h0000_0001, 32'h7F7F_FFFF, 1'b1);
      send_item(32'h0000_0001, 32'h4000_0000, 1'b0);
      send_item(32'h0000_0003, 32'h4000_0000, 1'b1);
      send_item(32'h007F_FFFF, 32'h3F80_0001, 1'b0);
      send_item(32'h8080_0000, 32'h3F7F_FFFF, 1'b1);
      send_item(32'h3F80_0000, 32'h7F80_0000, 1'b0);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_item(32'h8000_0000, 32'h3F80_0000, 1'b0);
      send_item(32'h4F00_0000, 32'h3400_0000, 1'b1);
      send_item(32'h3F80_0000, 32'h4040_0000, 1'b0);
      drain();
      random_items(300);
      drain();
      // signed zero bounds
      write_bound(CSR_CLAMP_LOW, 32'h8000_0000);
      write_bound(CSR_CLAMP_HIGH, 32'h0000_0000);
      send_item(32'h8000_0000, 32'h3F80_0000, 1'b0);
      send_item(32'h0000_0000, 32'h3F80_0000, 1'b1);
      random_items(40);
      drain();
      // nan bounds
      write_bound(CSR_CLAMP_LOW, 32'h7FC0_0000);
      write_bound(CSR_CLAMP_HIGH, 32'hFFFF_FFFF);
      send_item(32'h0000_0000, 32'h0000_0000, 1'b0);
      random_items(40);
      drain();
      // low bound above high bound
      write_bound(CSR_CLAMP_LOW, 32'h7F7F_FFFF);
      write_bound(CSR_CLAMP_HIGH, 32'h8000_0001);
      random_items(40);
      drain();
      for (int k = 0; k < 4; k++) begin
         write_bound(CSR_CLAMP_LOW, {1'b1, 8'(120 + $urandom_range(0, 14)), 23'($urandom)});
         write_bound(CSR_CLAMP_HIGH, $urandom);
         random_items(45);
         drain();
      end
      wait (pending_count == 0);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
